>>> src/assert_macros.svh
// assert_macros.svh: concurrent assertion macros used by roman_numeral_parser
// depends on nothing; define NO_ASSERTIONS to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define RNP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define RNP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RNP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RNP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> src/rnp_pkg.sv
// rnp_pkg: types, codes and small decode functions of the roman numeral parser
// depends on nothing; used by rnp_stream_if users, rnp_digit_match and the top level
package rnp_pkg;

	// item carried on the character channel
	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} symbol_item_t;

	// item carried on the result channel
	typedef struct packed {
		logic [11:0] value;
		logic        error;
	} result_item_t;

	// ascii letters that take part in a numeral
	localparam logic [7:0] ASCII_M = 8'h4D;
	localparam logic [7:0] ASCII_D = 8'h44;
	localparam logic [7:0] ASCII_C = 8'h43;
	localparam logic [7:0] ASCII_L = 8'h4C;
	localparam logic [7:0] ASCII_X = 8'h58;
	localparam logic [7:0] ASCII_V = 8'h56;
	localparam logic [7:0] ASCII_I = 8'h49;

	// parse phases
	localparam logic [2:0] PH_THOUS = 3'd0;
	localparam logic [2:0] PH_HUND  = 3'd1;
	localparam logic [2:0] PH_TENS  = 3'd2;
	localparam logic [2:0] PH_ONES  = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	// role of a letter inside its group
	localparam logic [1:0] CLS_UNIT = 2'd0;
	localparam logic [1:0] CLS_FIVE = 2'd1;
	localparam logic [1:0] CLS_TEN  = 2'd2;
	localparam logic [1:0] CLS_NONE = 2'd3;

	// group length limits
	localparam logic [2:0] GRP_SLOTS   = 3'd4;
	localparam logic [2:0] GRP_LEN_SAT = 3'd5;

	// weights and limits
	localparam int THOUSAND  = 1000;
	localparam int VALUE_MAX = 4095;
	localparam logic [9:0] RUN_MAX = 10'd999;

	// symbols of the open group, entry 0 first
	typedef logic [3:0][1:0] grp_syms_t;

	// pattern match result of one group
	typedef struct packed {
		logic       found;
		logic [3:0] digit;
	} digit_match_t;

	// role of a character in the group of a phase
	function automatic logic [1:0] classify(input logic [2:0] phase, input logic [7:0] c);
		logic [1:0] cls;
		cls = CLS_NONE;
		unique case (phase)
			PH_HUND: begin
				if (c == ASCII_C) cls = CLS_UNIT;
				else if (c == ASCII_D) cls = CLS_FIVE;
				else if (c == ASCII_M) cls = CLS_TEN;
			end
			PH_TENS: begin
				if (c == ASCII_X) cls = CLS_UNIT;
				else if (c == ASCII_L) cls = CLS_FIVE;
				else if (c == ASCII_C) cls = CLS_TEN;
			end
			PH_ONES: begin
				if (c == ASCII_I) cls = CLS_UNIT;
				else if (c == ASCII_V) cls = CLS_FIVE;
				else if (c == ASCII_X) cls = CLS_TEN;
			end
			default: cls = CLS_NONE;
		endcase
		return cls;
	endfunction

	// place value of the group of a phase
	function automatic logic [6:0] group_weight(input logic [2:0] phase);
		logic [6:0] w;
		unique case (phase)
			PH_HUND: w = 7'd100;
			PH_TENS: w = 7'd10;
			PH_ONES: w = 7'd1;
			default: w = 7'd0;
		endcase
		return w;
	endfunction

endpackage

>>> src/rnp_stream_if.sv
// rnp_stream_if: valid/ready channel carrying one item of a given type
// depends on nothing; item type is set per instance
interface rnp_stream_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/rnp_digit_match.sv
// rnp_digit_match: matches one collected group against the ten digit patterns
// depends on rnp_pkg
module rnp_digit_match (
	input  logic [2:0]              len,
	input  rnp_pkg::grp_syms_t      syms,
	output rnp_pkg::digit_match_t   match
);

	// only entries below len are looked at
	always_comb begin
		match.found = 1'b0;
		match.digit = 4'd0;
		case (len)
			3'd0: begin
				match.found = 1'b1;
			end
			3'd1: begin
				if (syms[0] == rnp_pkg::CLS_UNIT) begin
					match = '{found: 1'b1, digit: 4'd1};
				end else if (syms[0] == rnp_pkg::CLS_FIVE) begin
					match = '{found: 1'b1, digit: 4'd5};
				end
			end
			3'd2: begin
				if (syms[0] == rnp_pkg::CLS_UNIT && syms[1] == rnp_pkg::CLS_UNIT) begin
					match = '{found: 1'b1, digit: 4'd2};
				end else if (syms[0] == rnp_pkg::CLS_UNIT && syms[1] == rnp_pkg::CLS_FIVE) begin
					match = '{found: 1'b1, digit: 4'd4};
				end else if (syms[0] == rnp_pkg::CLS_FIVE && syms[1] == rnp_pkg::CLS_UNIT) begin
					match = '{found: 1'b1, digit: 4'd6};
				end else if (syms[0] == rnp_pkg::CLS_UNIT && syms[1] == rnp_pkg::CLS_TEN) begin
					match = '{found: 1'b1, digit: 4'd9};
				end
			end
			3'd3: begin
				if (syms[1] == rnp_pkg::CLS_UNIT && syms[2] == rnp_pkg::CLS_UNIT) begin
					if (syms[0] == rnp_pkg::CLS_UNIT) begin
						match = '{found: 1'b1, digit: 4'd3};
					end else if (syms[0] == rnp_pkg::CLS_FIVE) begin
						match = '{found: 1'b1, digit: 4'd7};
					end
				end
			end
			3'd4: begin
				if (syms[0] == rnp_pkg::CLS_FIVE && syms[1] == rnp_pkg::CLS_UNIT
						&& syms[2] == rnp_pkg::CLS_UNIT && syms[3] == rnp_pkg::CLS_UNIT) begin
					match = '{found: 1'b1, digit: 4'd8};
				end
			end
			default: begin
				match.found = 1'b0;
			end
		endcase
	end

endmodule

>>> src/roman_numeral_parser.sv
// roman_numeral_parser: decodes a roman numeral streamed one ascii character per item
// depends on rnp_pkg, rnp_stream_if, rnp_digit_match and assert_macros.svh
//
//   channel   dir   item fields          transfer
//   chars     in    symbol[7:0], last    valid & ready
//   result    out   value[11:0], error   valid & ready, one item per last character
//
// one character is taken every cycle while chars.ready is high; the group state
// updates in the same cycle. the item with last set is snapshotted into stage
// s1, where the open group is closed and the total formed; that total is then
// held in the output register, which drives result.valid and result.data.
// a held result does not stop characters: chars.ready drops only when s1 and the
// output register are both full and result.ready is low.
// arst_n clears phase, counts, sticky error and all valid flags.
`include "assert_macros.svh"
module roman_numeral_parser #(
	parameter int MAX_THOUSANDS = 3
) (
	input logic          clk,
	input logic          arst_n,
	rnp_stream_if.sink   chars,
	rnp_stream_if.source result
);

	localparam int TCW     = $clog2(MAX_THOUSANDS + 1);
	localparam int TOT_RAW = $clog2((MAX_THOUSANDS + 1) * rnp_pkg::THOUSAND);
	localparam int TOTW    = (TOT_RAW > 13) ? TOT_RAW : 13;

	// parse state
	logic [2:0]         phase_q;
	logic [TCW-1:0]     thous_q;
	rnp_pkg::grp_syms_t syms_q;
	logic [2:0]         len_q;
	logic [9:0]         run_q;
	logic               err_q;

	// next parse state
	logic [2:0]         phase_d;
	logic [TCW-1:0]     thous_d;
	rnp_pkg::grp_syms_t syms_d;
	logic [2:0]         len_d;
	logic [9:0]         run_d;
	logic               err_d;

	// finished numeral waiting for its total
	logic               s1_valid_q;
	logic [2:0]         phase_s1;
	logic [TCW-1:0]     thous_s1;
	rnp_pkg::grp_syms_t syms_s1;
	logic [2:0]         len_s1;
	logic [9:0]         run_s1;
	logic               err_s1;

	// output register
	logic                  out_valid_q;
	rnp_pkg::result_item_t out_item_q;
	rnp_pkg::result_item_t out_item_d;

	logic accept_in;
	logic advance_out;

	logic [2:0]            eff_phase;
	logic [2:0]            eff_len;
	logic [1:0]            cls_tens;
	logic [1:0]            cls_ones;
	logic [1:0]            cls_eff;
	rnp_pkg::digit_match_t match_a;
	rnp_pkg::digit_match_t match_b;

	logic            close_b;
	logic [9:0]      add_b;
	logic [TOTW-1:0] total_b;
	logic            err_b;

	// handshake
	assign advance_out  = !out_valid_q || result.ready;
	assign chars.ready  = !s1_valid_q || advance_out;
	assign accept_in    = chars.valid && chars.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_item_q;

	// group the character is offered to first
	assign eff_phase = (phase_q == rnp_pkg::PH_THOUS) ? rnp_pkg::PH_HUND : phase_q;
	assign eff_len   = (phase_q == rnp_pkg::PH_THOUS) ? 3'd0 : len_q;
	assign cls_tens  = rnp_pkg::classify(rnp_pkg::PH_TENS, chars.data.symbol);
	assign cls_ones  = rnp_pkg::classify(rnp_pkg::PH_ONES, chars.data.symbol);
	assign cls_eff   = rnp_pkg::classify(eff_phase, chars.data.symbol);

	// match of the group a foreign character closes
	rnp_digit_match u_match_a (
		.len   (eff_len),
		.syms  (syms_q),
		.match (match_a)
	);

	// character update of the parse state
	always_comb begin
		phase_d = phase_q;
		thous_d = thous_q;
		syms_d  = syms_q;
		len_d   = len_q;
		run_d   = run_q;
		err_d   = err_q;
		if (phase_q == rnp_pkg::PH_THOUS && chars.data.symbol == rnp_pkg::ASCII_M) begin
			if (thous_q < TCW'(MAX_THOUSANDS)) begin
				thous_d = thous_q + TCW'(1);
			end else begin
				err_d = 1'b1;
			end
		end else if (phase_q != rnp_pkg::PH_DONE) begin
			if (cls_eff != rnp_pkg::CLS_NONE) begin
				phase_d = eff_phase;
				len_d   = eff_len;
				if (eff_len < rnp_pkg::GRP_SLOTS) begin
					syms_d[eff_len[1:0]] = cls_eff;
				end
				if (eff_len < rnp_pkg::GRP_LEN_SAT) begin
					len_d = eff_len + 3'd1;
				end
			end else begin
				// close the group, later empty groups are digit zero
				if (match_a.found) begin
					run_d = run_q + 10'(match_a.digit) * 10'(rnp_pkg::group_weight(eff_phase));
				end else begin
					err_d = 1'b1;
				end
				if (eff_phase < rnp_pkg::PH_TENS && cls_tens != rnp_pkg::CLS_NONE) begin
					phase_d   = rnp_pkg::PH_TENS;
					len_d     = 3'd1;
					syms_d[0] = cls_tens;
				end else if (eff_phase < rnp_pkg::PH_ONES && cls_ones != rnp_pkg::CLS_NONE) begin
					phase_d   = rnp_pkg::PH_ONES;
					len_d     = 3'd1;
					syms_d[0] = cls_ones;
				end else begin
					phase_d = rnp_pkg::PH_DONE;
					len_d   = 3'd0;
				end
			end
		end
	end

	// parse state registers, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rnp_pkg::PH_THOUS;
			thous_q <= '0;
			len_q   <= '0;
			run_q   <= '0;
			err_q   <= 1'b0;
		end else if (accept_in) begin
			if (chars.data.last) begin
				phase_q <= rnp_pkg::PH_THOUS;
				thous_q <= '0;
				len_q   <= '0;
				run_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				thous_q <= thous_d;
				len_q   <= len_d;
				run_q   <= run_d;
				err_q   <= err_d;
			end
		end
	end

	// group symbols hold no reset
	always_ff @(posedge clk) begin
		if (accept_in) begin
			syms_q <= syms_d;
		end
	end

	// snapshot of a finished numeral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept_in && chars.data.last) begin
			s1_valid_q <= 1'b1;
		end else if (advance_out) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && chars.data.last) begin
			phase_s1 <= phase_d;
			thous_s1 <= thous_d;
			syms_s1  <= syms_d;
			len_s1   <= len_d;
			run_s1   <= run_d;
			err_s1   <= err_d;
		end
	end

	// match of the group still open at the end
	rnp_digit_match u_match_b (
		.len   (len_s1),
		.syms  (syms_s1),
		.match (match_b)
	);

	// close the open group and form the total
	always_comb begin
		close_b = (phase_s1 == rnp_pkg::PH_HUND) || (phase_s1 == rnp_pkg::PH_TENS)
			|| (phase_s1 == rnp_pkg::PH_ONES);
		add_b = '0;
		if (close_b && match_b.found) begin
			add_b = 10'(match_b.digit) * 10'(rnp_pkg::group_weight(phase_s1));
		end
		total_b = TOTW'(thous_s1) * TOTW'(rnp_pkg::THOUSAND) + TOTW'(run_s1) + TOTW'(add_b);
		err_b   = err_s1 || (close_b && !match_b.found) || (total_b > TOTW'(rnp_pkg::VALUE_MAX));
		out_item_d.error = err_b;
		out_item_d.value = err_b ? 12'd0 : total_b[11:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_out) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_out && s1_valid_q) begin
			out_item_q <= out_item_d;
		end
	end

	// checks
	`RNP_ASSERT(a_s1_from_last, clk, arst_n,
		$rose(s1_valid_q) |-> $past(accept_in && chars.data.last),
		"numeral snapshot without a last item")
	`RNP_ASSERT(a_reset_after_last, clk, arst_n,
		(accept_in && chars.data.last) |=> (phase_q == rnp_pkg::PH_THOUS
			&& thous_q == '0 && len_q == '0 && !err_q),
		"parse state not cleared after last item")
	`RNP_ASSERT_NEVER(a_run_range, clk, arst_n,
		run_q > rnp_pkg::RUN_MAX,
		"running value beyond three digits")
	`RNP_ASSERT(a_err_zero, clk, arst_n,
		(out_valid_q && out_item_q.error) |-> (out_item_q.value == 12'd0),
		"error result carries a value")
	`RNP_ASSERT(a_s1_hold, clk, arst_n,
		(s1_valid_q && !advance_out) |=> s1_valid_q,
		"finished numeral dropped during output stall")

endmodule
